// ----- rtl/bb3_pkg.sv -----
// bb3_pkg: shared constants, types and helpers for the 3x3 box blur core.
// Used by every module of the block; depends on nothing.
package bb3_pkg;

   localparam int MAX_WIDTH = 64;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WCFG_W    = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W     = 16;
   localparam int ADDR_W    = $clog2(3 * MAX_WIDTH);
   localparam int PIX_W     = 24;

   // configuration register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // one accepted pixel with its position and the results it releases
   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [1:0]       slot;
      logic [3:0]       mask;
   } cmd_type;

   function automatic logic [1:0] slot_dec(input logic [1:0] s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

   function automatic logic [1:0] slot_inc(input logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   // ceil(2^16 / count); exact floor division for dividends below 2^13
   function automatic logic [16:0] recip_of(input logic [3:0] c);
      logic [16:0] r;
      unique case (c)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/box_blur_3x3_edge_clamped_core.sv -----
// Channel   | Ports                                     | Direction
// req       | req_valid, req_stall, req_red/green/blue  | pixel in, raster order
// rsp       | rsp_valid, rsp_stall, rsp_row/col/rgb,    | blurred pixel out
//           | rsp_run_last                              |
// csr       | csr_we, csr_index, csr_wdata              | frame width, height
//
// A pixel passes through the back end as a queue pop and a final select, plus,
// for each result it releases (0 to 4), a select, nine window taps through the
// single line-store read port, a drain, a load, one reciprocal multiply and the
// output. Reset is synchronous and clears counters, queue and result valid; the
// line stores are not cleared. A stalled result holds while the front keeps
// taking up to two pixels into its queue.
module box_blur_3x3_edge_clamped_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [bb3_pkg::ROW_W-1:0] rsp_row,
   output logic [bb3_pkg::COL_W-1:0] rsp_col,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic                      rsp_run_last,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [15:0]               csr_wdata
);
   import bb3_pkg::*;

   logic [6:0]        width_ff;
   logic [15:0]       height_ff;
   logic [WCFG_W-1:0] eff_w;
   logic [ROW_W-1:0]  eff_h;
   logic              q_full, q_empty, q_push, q_pop;
   cmd_type           push_data, pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 16'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_wdata[6:0];
            REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp to the supported frame
   always_comb begin
      if (width_ff == 7'd0) eff_w = WCFG_W'(1);
      else if (32'(width_ff) > MAX_WIDTH) eff_w = WCFG_W'(MAX_WIDTH);
      else eff_w = WCFG_W'(width_ff);
      eff_h = (height_ff == 16'd0) ? ROW_W'(1) : height_ff;
   end

   bb3_front u_front (
      .clock, .reset, .req_valid, .req_red, .req_green, .req_blue, .req_stall,
      .eff_w, .eff_h, .q_full, .q_push, .q_data(push_data)
   );

   bb3_queue u_queue (
      .clock, .reset, .push(q_push), .push_data, .pop(q_pop), .pop_data,
      .full(q_full), .empty(q_empty)
   );

   bb3_back u_back (
      .clock, .reset, .eff_w, .eff_h, .q_empty, .q_data(pop_data), .q_pop,
      .rsp_valid, .rsp_stall, .rsp_row, .rsp_col, .rsp_red, .rsp_green,
      .rsp_blue, .rsp_run_last
   );

endmodule

// ----- rtl/bb3_front.sv -----
// bb3_front: accepts pixels, tracks row/column/slot and classifies which
// results each pixel releases. Depends on bb3_pkg.
module bb3_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      req_stall,
   input  logic [bb3_pkg::WCFG_W-1:0] eff_w,
   input  logic [bb3_pkg::ROW_W-1:0]  eff_h,
   input  logic                      q_full,
   output logic                      q_push,
   output bb3_pkg::cmd_type          q_data
);
   import bb3_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       slot_ff, slot_in;
   logic             end_col, last_row, has_up, has_left;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // classify the position of the incoming pixel
   always_comb begin
      end_col  = {1'b0, col_ff} >= (eff_w - WCFG_W'(1));
      last_row = row_ff >= (eff_h - ROW_W'(1));
      has_up   = row_ff != '0;
      has_left = col_ff != '0;
      q_data.red   = req_red;
      q_data.green = req_green;
      q_data.blue  = req_blue;
      q_data.row   = row_ff;
      q_data.col   = col_ff;
      q_data.slot  = slot_ff;
      q_data.mask  = {last_row && end_col, last_row && has_left,
                      has_up && end_col, has_up && has_left};
   end

   // advance the raster position on each beat
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      slot_in = slot_ff;
      if (q_push) begin
         if (end_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = 2'd0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               slot_in = slot_inc(slot_ff);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= 2'd0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         slot_ff <= slot_in;
      end
   end

endmodule

// ----- rtl/bb3_queue.sv -----
// bb3_queue: two-entry queue of classified pixels between front and back.
// Depends on bb3_pkg.
module bb3_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bb3_pkg::cmd_type push_data,
   input  logic             pop,
   output bb3_pkg::cmd_type pop_data,
   output logic             full,
   output logic             empty
);
   import bb3_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/bb3_back.sv -----
// bb3_back: writes line stores, sums each 3x3 window one tap a cycle,
// divides by reciprocal multiplication and drives the result register. Depends on bb3_pkg.
module bb3_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bb3_pkg::WCFG_W-1:0] eff_w,
   input  logic [bb3_pkg::ROW_W-1:0]  eff_h,
   input  logic                       q_empty,
   input  bb3_pkg::cmd_type           q_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [bb3_pkg::ROW_W-1:0]  rsp_row,
   output logic [bb3_pkg::COL_W-1:0]  rsp_col,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue,
   output logic                       rsp_run_last
);
   import bb3_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEL   = 3'd1;
   localparam logic [2:0] S_TAP   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [PIX_W-1:0]  mem [3 * MAX_WIDTH];
   logic [2:0]        state_ff;
   cmd_type           cmd_ff;
   logic [3:0]        mask_ff, cur_ff;
   logic [ROW_W-1:0]  crow_ff;
   logic [COL_W-1:0]  ccol_ff;
   logic [1:0]        cslot_ff;
   logic [1:0]        dr_ff, dc_ff;
   logic              tap_ok_ff;
   logic [PIX_W-1:0]  rdata_ff;
   logic [11:0]       sum_r_ff, sum_g_ff, sum_b_ff;
   logic [3:0]        cnt_ff;
   logic [11:0]       dvd_r_ff, dvd_g_ff, dvd_b_ff;
   logic [16:0]       recip_ff;
   logic [7:0]        mean_r_ff, mean_g_ff, mean_b_ff;
   logic [28:0]       prod_r, prod_g, prod_b;
   logic              out_free;
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [7:0]        rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic              rsp_last_ff;
   logic [ROW_W:0]    tap_row;
   logic [COL_W:0]    tap_col;
   logic              ok_row, ok_col;
   logic [1:0]        tap_slot;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [3:0]        low_bit;

   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // tap address and in-frame test for the current window position
   always_comb begin
      tap_row  = {1'b0, crow_ff} + (ROW_W + 1)'(dr_ff) - (ROW_W + 1)'(1);
      tap_col  = {1'b0, ccol_ff} + (COL_W + 1)'(dc_ff) - (COL_W + 1)'(1);
      ok_row   = !(dr_ff == 2'd0 && crow_ff == '0) && (tap_row < {1'b0, eff_h});
      ok_col   = !(dc_ff == 2'd0 && ccol_ff == '0) && (tap_col < eff_w);
      tap_slot = (dr_ff == 2'd0) ? slot_dec(cslot_ff) :
                 (dr_ff == 2'd2) ? slot_inc(cslot_ff) : cslot_ff;
      rd_addr  = ADDR_W'(tap_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tap_col[COL_W-1:0]);
      wr_addr  = ADDR_W'(q_data.slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(q_data.col);
      low_bit  = mask_ff & (~mask_ff + 4'd1);
   end

   // line stores: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (q_pop) mem[wr_addr] <= {q_data.red, q_data.green, q_data.blue};
      rdata_ff <= mem[rd_addr];
   end

   // divide by the tap count through its reciprocal
   always_comb begin
      prod_r = 29'(dvd_r_ff) * 29'(recip_ff);
      prod_g = 29'(dvd_g_ff) * 29'(recip_ff);
      prod_b = 29'(dvd_b_ff) * 29'(recip_ff);
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_ok_ff <= (state_ff == S_TAP) && ok_row && ok_col;
         if (state_ff == S_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  cmd_ff   <= q_data;
                  mask_ff  <= q_data.mask;
                  state_ff <= S_SEL;
               end
            end
            S_SEL: begin
               if (mask_ff == 4'd0) begin
                  state_ff <= S_IDLE;
               end else begin
                  cur_ff   <= low_bit;
                  crow_ff  <= (low_bit[0] || low_bit[1]) ? cmd_ff.row - ROW_W'(1)
                                                        : cmd_ff.row;
                  cslot_ff <= (low_bit[0] || low_bit[1]) ? slot_dec(cmd_ff.slot)
                                                        : cmd_ff.slot;
                  ccol_ff  <= (low_bit[0] || low_bit[2]) ? cmd_ff.col - COL_W'(1)
                                                        : cmd_ff.col;
                  dr_ff    <= 2'd0;
                  dc_ff    <= 2'd0;
                  sum_r_ff <= '0;
                  sum_g_ff <= '0;
                  sum_b_ff <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_TAP;
               end
            end
            S_TAP: begin
               if (dc_ff == 2'd2) begin
                  dc_ff <= 2'd0;
                  dr_ff <= dr_ff + 2'd1;
                  if (dr_ff == 2'd2) state_ff <= S_DRAIN;
               end else begin
                  dc_ff <= dc_ff + 2'd1;
               end
            end
            S_DRAIN: state_ff <= S_LOAD;
            S_LOAD: begin
               // floor((2*sum + n) / (2*n)) equals floor((sum + n/2) / n)
               dvd_r_ff <= sum_r_ff + 12'(cnt_ff[3:1]);
               dvd_g_ff <= sum_g_ff + 12'(cnt_ff[3:1]);
               dvd_b_ff <= sum_b_ff + 12'(cnt_ff[3:1]);
               recip_ff <= recip_of(cnt_ff);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               mean_r_ff <= prod_r[23:16];
               mean_g_ff <= prod_g[23:16];
               mean_b_ff <= prod_b[23:16];
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  mask_ff  <= mask_ff & ~cur_ff;
                  state_ff <= S_SEL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // accumulate the tap read in the previous cycle
         if (tap_ok_ff) begin
            sum_r_ff <= sum_r_ff + 12'(rdata_ff[23:16]);
            sum_g_ff <= sum_g_ff + 12'(rdata_ff[15:8]);
            sum_b_ff <= sum_b_ff + 12'(rdata_ff[7:0]);
            cnt_ff   <= cnt_ff + 4'd1;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_row_ff   <= crow_ff;
         rsp_col_ff   <= ccol_ff;
         rsp_red_ff   <= (cnt_ff == '0) ? 8'd0 : mean_r_ff;
         rsp_green_ff <= (cnt_ff == '0) ? 8'd0 : mean_g_ff;
         rsp_blue_ff  <= (cnt_ff == '0) ? 8'd0 : mean_b_ff;
         rsp_last_ff  <= (mask_ff & ~cur_ff) == 4'd0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_col      = rsp_col_ff;
   assign rsp_red      = rsp_red_ff;
   assign rsp_green    = rsp_green_ff;
   assign rsp_blue     = rsp_blue_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

// ----- rtl/bb3_checker.sv -----
// bb3_checker: port-level checks on the box blur core, bound to the top.
// Depends on bb3_pkg and box_blur_3x3_edge_clamped_core.
module bb3_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [bb3_pkg::ROW_W-1:0] rsp_row,
   input logic [bb3_pkg::COL_W-1:0] rsp_col,
   input logic [7:0]                rsp_red
);
   import bb3_pkg::*;

   // a stalled beat stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row) && $stable(rsp_col))
      else $error("stalled result changed");

   // reset empties the queue and the result register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state survived reset");

   // a stalled value holds
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red))
      else $error("stalled value changed");

endmodule

bind box_blur_3x3_edge_clamped_core bb3_checker u_bb3_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_row, .rsp_col, .rsp_red
);

// ----- sim/tb_box_blur_3x3_edge_clamped_core.sv -----
// Self-checking testbench for box_blur_3x3_edge_clamped_core: streams whole frames
// under many frame sizes and predicts every blurred pixel in a scoreboard class.
// Depends on bb3_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_box_blur_3x3_edge_clamped_core;
   import bb3_pkg::*;

   localparam int   STORE_DEPTH = 3 * MAX_WIDTH;
   localparam int   SETTLE_CYCLES = 150;
   localparam int   WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic             last;
   } blur_pixel_type;

   // Predicts blurred pixels and checks them in order
   class blur_scoreboard;
      logic [PIX_W-1:0] line_rows [STORE_DEPTH];
      logic [ROW_W-1:0] row_pos;
      logic [COL_W-1:0] col_pos;
      logic [6:0]       width_reg;
      logic [15:0]      height_reg;
      blur_pixel_type   expected_q [$];
      int errors;
      int results_seen;

      function new();
         row_pos = '0;
         col_pos = '0;
         width_reg = 7'd64;
         height_reg = 16'd64;
         errors = 0;
         results_seen = 0;
      endfunction

      function void set_reg(logic index, logic [15:0] data);
         if (index == REG_WIDTH) width_reg = data[6:0];
         else height_reg = data;
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int eff_height();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function logic [7:0] rounded_mean(int sum, int count);
         if (count == 0) return 8'd0;
         return 8'((2 * sum + count) / (2 * count));
      endfunction

      // Average the in-frame part of the window centered on (r, c)
      function void push_blur(int r, int c);
         int w, h, rr, cc, count;
         int sum_r, sum_g, sum_b;
         logic [PIX_W-1:0] px;
         blur_pixel_type bp;
         w = eff_width();
         h = eff_height();
         count = 0; sum_r = 0; sum_g = 0; sum_b = 0;
         for (rr = r - 1; rr <= r + 1; rr++) begin
            if (rr < 0 || rr >= h) continue;
            for (cc = c - 1; cc <= c + 1; cc++) begin
               if (cc < 0 || cc >= w) continue;
               px = line_rows[(rr % 3) * MAX_WIDTH + cc];
               sum_r += px[23:16];
               sum_g += px[15:8];
               sum_b += px[7:0];
               count++;
            end
         end
         bp.row = ROW_W'(r);
         bp.col = COL_W'(c);
         bp.red = rounded_mean(sum_r, count);
         bp.green = rounded_mean(sum_g, count);
         bp.blue = rounded_mean(sum_b, count);
         bp.last = 1'b0;
         expected_q.push_back(bp);
      endfunction

      function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         int w, h, r, c, prior_count;
         bit end_col, last_row;
         w = eff_width();
         h = eff_height();
         r = row_pos;
         c = col_pos;
         end_col = c >= w - 1;
         last_row = r >= h - 1;
         prior_count = expected_q.size();
         line_rows[(r % 3) * MAX_WIDTH + c] = {red, green, blue};
         if (r >= 1) begin
            if (c >= 1) push_blur(r - 1, c - 1);
            if (end_col) push_blur(r - 1, c);
         end
         if (last_row) begin
            if (c >= 1) push_blur(r, c - 1);
            if (end_col) push_blur(r, c);
         end
         if (expected_q.size() > prior_count) expected_q[expected_q.size() - 1].last = 1'b1;
         // advance the raster position
         if (end_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
         end else begin
            col_pos = col_pos + 1'b1;
         end
      endfunction

      function void check_result(blur_pixel_type got);
         blur_pixel_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected beat row %0d col %0d", got.row, got.col);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: expected r%0d c%0d rgb %h %h %h last %b, got r%0d c%0d rgb %h %h %h last %b",
                        want.row, want.col, want.red, want.green, want.blue, want.last,
                        got.row, got.col, got.red, got.green, got.blue, got.last);
         end
      endfunction

      function bit at_frame_start();
         return row_pos == 0 && col_pos == 0;
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_red, req_green, req_blue;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [ROW_W-1:0] rsp_row;
   logic [COL_W-1:0] rsp_col;
   logic [7:0]       rsp_red, rsp_green, rsp_blue;
   logic             rsp_run_last;
   logic             csr_we;
   logic             csr_index;
   logic [15:0]      csr_wdata;

   blur_scoreboard sb = new();
   bit idle_on = 1'b1;
   int pixels_sent = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   box_blur_3x3_edge_clamped_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_row, rsp_col, rsp_red, rsp_green, rsp_blue, rsp_run_last});
      rsp_stall <= idle_on && ($urandom_range(99) < 32);
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: watchdog expired");
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(logic index, logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(index, data);
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      // idle gap before the beat
      while (idle_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= red;
      req_green <= green;
      req_blue <= blue;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(red, green, blue);
      pixels_sent++;
   endtask

   task automatic send_random_pixels(int count);
      repeat (count) send_pixel($urandom, $urandom, $urandom);
   endtask

   // Hold off until every result is back and the core is quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_frames(logic [15:0] width_val, logic [15:0] height_val, int frames);
      write_reg(REG_WIDTH, width_val);
      write_reg(REG_HEIGHT, height_val);
      settings_used++;
      send_random_pixels(frames * sb.eff_width() * sb.eff_height());
      drain();
   endtask

   initial begin
      logic [15:0] w, h;
      int phase;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_red <= '0;
      req_green <= '0;
      req_blue <= '0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= REG_WIDTH;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single pixel frames at full and zero intensity, zero sizes
      write_reg(REG_WIDTH, 16'd1);
      write_reg(REG_HEIGHT, 16'd1);
      send_pixel(8'hff, 8'hff, 8'hff);
      drain();
      write_reg(REG_WIDTH, 16'd0);
      write_reg(REG_HEIGHT, 16'd0);
      send_pixel(8'h00, 8'h00, 8'h00);
      drain();
      // small frames with extreme values, corners and edges
      write_reg(REG_WIDTH, 16'd2);
      write_reg(REG_HEIGHT, 16'd2);
      send_pixel(8'hff, 8'h00, 8'hff);
      send_pixel(8'h00, 8'hff, 8'h00);
      send_pixel(8'h01, 8'hfe, 8'h80);
      send_pixel(8'h7f, 8'h01, 8'hfe);
      drain();
      run_frames(16'd3, 16'd3, 1);
      settings_used += 3;

      // Directed: shrink the frame while inside it, leaving empty windows
      write_reg(REG_WIDTH, 16'd8);
      write_reg(REG_HEIGHT, 16'hffff);
      send_random_pixels(8 * 5 + 3);
      drain();
      write_reg(REG_HEIGHT, 16'd3);
      write_reg(REG_WIDTH, 16'd2);
      send_random_pixels(1);
      drain();
      settings_used++;

      // Random frames; one stretch with no idling on either side
      phase = 0;
      while (pixels_sent < 430) begin
         idle_on = !(phase >= 4 && phase < 9);
         case ($urandom_range(9))
            0:       w = 16'd64;
            1:       w = 16'($urandom_range(65, 127));
            2:       w = 16'd0;
            default: w = 16'($urandom_range(1, 10));
         endcase
         w = {7'($urandom), 2'b00, w[6:0]};
         if (w[6:0] >= 64) h = 16'($urandom_range(0, 2));
         else if ($urandom_range(9) == 0) h = 16'd0;
         else h = 16'($urandom_range(1, 6));
         run_frames(w, h, $urandom_range(1, 2));
         phase++;
      end
      idle_on = 1'b1;

      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.errors += sb.expected_q.size();
      $display("Covered %0d pixels, %0d blurred results, %0d frame settings.",
               pixels_sent, sb.results_seen, settings_used);
      $display("Frame sizes ranged from one pixel to full width, with a mid-frame shrink.");
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d errors", sb.errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
